[design/sfr_pkg.sv]
package sfr_pkg;

    localparam int BUFFER_BYTES_DEF  = 64;
    localparam int PATTERN_BYTES_DEF = 16;
    localparam int BYTE_W            = 8;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [1:0]        cmd_code_t;
    typedef logic [1:0]        status_t;

    // Load commands
    localparam cmd_code_t CMD_PATTERN = 2'd0;
    localparam cmd_code_t CMD_REPLACE = 2'd1;
    localparam cmd_code_t CMD_TEXT    = 2'd2;

    // Result status codes
    localparam status_t STATUS_REPLACED  = 2'd0;
    localparam status_t STATUS_TOO_LONG  = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_OVERFLOW  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } sfr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    search_init;
        logic    search_rd;
        logic    next_k;
        logic    next_pos;
        logic    finish;
        status_t finish_status;
        logic    finish_replace;
        logic    emit_rd;
        logic    emit_load;
        logic    clear_job;
    } sfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_item;
        logic overflow;
        logic pat_fits;
        logic pat_empty;
        logic byte_eq;
        logic k_last;
        logic too_long;
        logic emit_last;
        logic out_free;
    } sfr_stat_t;

endpackage

[design/sfr_load_if.sv]
interface sfr_load_if;
    import sfr_pkg::*;

    logic      valid;
    logic      ready;
    cmd_code_t command;
    byte_t     data_byte;
    logic      end_of_text;

    modport source (output valid, output command, output data_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input end_of_text,
                    output ready);
endinterface

[design/sfr_result_if.sv]
interface sfr_result_if;
    import sfr_pkg::*;

    logic    valid;
    logic    ready;
    byte_t   out_byte;
    status_t status;
    logic    last_out;

    modport source (output valid, output out_byte, output status, output last_out,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_out,
                    output ready);
endinterface

[design/sfr_ram.sv]
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/sfr_datapath.sv]
module sfr_datapath #(
    parameter int BUFFER_BYTES  = sfr_pkg::BUFFER_BYTES_DEF,
    parameter int PATTERN_BYTES = sfr_pkg::PATTERN_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfr_pkg::cmd_code_t command,
    input  sfr_pkg::byte_t     data_byte,
    input  logic               end_of_text,
    input  sfr_pkg::sfr_cmd_t  cmd,
    output sfr_pkg::sfr_stat_t st,
    output logic               out_valid,
    input  logic               out_ready,
    output sfr_pkg::byte_t     out_byte,
    output sfr_pkg::status_t   status,
    output logic               last_out
);
    import sfr_pkg::*;

    localparam int TAW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int PAW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int TCW = $clog2(BUFFER_BYTES + 1);
    localparam int PCW = $clog2(PATTERN_BYTES + 1);
    localparam int SW  = ((TCW > PCW) ? TCW : PCW) + 1;

    localparam logic [TCW-1:0] TEXT_FULL = TCW'(BUFFER_BYTES);
    localparam logic [PCW-1:0] PAT_FULL  = PCW'(PATTERN_BYTES);
    localparam logic [SW-1:0]  BUF_LIMIT = SW'(BUFFER_BYTES);

    logic [TCW-1:0] text_count_reg, text_count_next;
    logic [PCW-1:0] pattern_count_reg, pattern_count_next;
    logic [PCW-1:0] repl_count_reg, repl_count_next;
    logic           overflow_reg, overflow_next;
    logic [TCW-1:0] pos_reg, pos_next;
    logic [PCW-1:0] k_reg, k_next;
    logic [TCW-1:0] idx_reg, idx_next;
    logic [TCW-1:0] len_reg, len_next;
    status_t        status_reg, status_next;
    logic           replaced_reg, replaced_next;
    logic           sel_repl_reg, sel_repl_next;
    logic           out_valid_reg, out_valid_next;
    byte_t          out_byte_reg, out_byte_next;
    status_t        out_status_reg, out_status_next;
    logic           out_last_reg, out_last_next;

    logic           txt_we, pat_we, rep_we;
    logic           txt_re;
    logic [TAW-1:0] txt_raddr;
    byte_t          txt_rdata, pat_rdata, rep_rdata;

    logic [SW-1:0]  pos_w, k_w, tc_w, pc_w, rc_w, idx_w, len_w;
    logic [SW-1:0]  search_addr_w, text_emit_w, repl_addr_w, newlen_w;
    logic           emit_before, emit_in_repl;

    assign pos_w = SW'(pos_reg);
    assign k_w   = SW'(k_reg);
    assign tc_w  = SW'(text_count_reg);
    assign pc_w  = SW'(pattern_count_reg);
    assign rc_w  = SW'(repl_count_reg);
    assign idx_w = SW'(idx_reg);
    assign len_w = SW'(len_reg);

    assign search_addr_w = pos_w + k_w;
    assign newlen_w      = tc_w + rc_w - pc_w;

    // Output byte idx comes from the text before the match, from the replacement,
    // or from the text shifted by the difference in length after it.
    assign emit_before  = idx_w < pos_w;
    assign emit_in_repl = replaced_reg && !emit_before && (idx_w < pos_w + rc_w);
    assign text_emit_w  = (replaced_reg && !emit_before) ? idx_w + pc_w - rc_w : idx_w;
    assign repl_addr_w  = idx_w - pos_w;

    assign txt_re    = cmd.search_rd || cmd.emit_rd;
    assign txt_raddr = cmd.emit_rd ? text_emit_w[TAW-1:0] : search_addr_w[TAW-1:0];

    sfr_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_BYTES)) u_text_ram (
        .clk   (clk),
        .we    (txt_we),
        .waddr (text_count_reg[TAW-1:0]),
        .wdata (data_byte),
        .re    (txt_re),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    sfr_ram #(.WIDTH(BYTE_W), .DEPTH(PATTERN_BYTES)) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pattern_count_reg[PAW-1:0]),
        .wdata (data_byte),
        .re    (cmd.search_rd),
        .raddr (k_reg[PAW-1:0]),
        .rdata (pat_rdata)
    );

    sfr_ram #(.WIDTH(BYTE_W), .DEPTH(PATTERN_BYTES)) u_repl_ram (
        .clk   (clk),
        .we    (rep_we),
        .waddr (repl_count_reg[PAW-1:0]),
        .wdata (data_byte),
        .re    (cmd.emit_rd),
        .raddr (repl_addr_w[PAW-1:0]),
        .rdata (rep_rdata)
    );

    always_comb
    begin
        st.start_item = (command == CMD_TEXT) && end_of_text;
        st.overflow   = overflow_reg;
        st.pat_fits   = (pos_w + pc_w) <= tc_w;
        st.pat_empty  = (pattern_count_reg == '0);
        st.byte_eq    = (txt_rdata == pat_rdata);
        st.k_last     = (k_w + SW'(1)) == pc_w;
        st.too_long   = (tc_w + rc_w) >= (pc_w + BUF_LIMIT);
        st.emit_last  = (idx_w + SW'(1)) >= len_w;
        st.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        text_count_next    = text_count_reg;
        pattern_count_next = pattern_count_reg;
        repl_count_next    = repl_count_reg;
        overflow_next      = overflow_reg;
        pos_next           = pos_reg;
        k_next             = k_reg;
        idx_next           = idx_reg;
        len_next           = len_reg;
        status_next        = status_reg;
        replaced_next      = replaced_reg;
        sel_repl_next      = sel_repl_reg;
        out_valid_next     = out_valid_reg;
        out_byte_next      = out_byte_reg;
        out_status_next    = out_status_reg;
        out_last_next      = out_last_reg;
        txt_we             = 1'b0;
        pat_we             = 1'b0;
        rep_we             = 1'b0;

        // A byte sent to a full store is dropped and flags the job.
        if (cmd.load)
        begin
            unique case (command)
                CMD_PATTERN:
                begin
                    if (pattern_count_reg < PAT_FULL)
                    begin
                        pat_we             = 1'b1;
                        pattern_count_next = pattern_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                CMD_REPLACE:
                begin
                    if (repl_count_reg < PAT_FULL)
                    begin
                        rep_we          = 1'b1;
                        repl_count_next = repl_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                CMD_TEXT:
                begin
                    if (text_count_reg < TEXT_FULL)
                    begin
                        txt_we          = 1'b1;
                        text_count_next = text_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.clear_job)
        begin
            text_count_next    = '0;
            pattern_count_next = '0;
            repl_count_next    = '0;
            overflow_next      = 1'b0;
        end

        if (cmd.search_init)
        begin
            pos_next = '0;
            k_next   = '0;
        end
        if (cmd.next_k)
        begin
            k_next = k_reg + 1'b1;
        end
        if (cmd.next_pos)
        begin
            pos_next = pos_reg + 1'b1;
            k_next   = '0;
        end

        if (cmd.finish)
        begin
            status_next   = cmd.finish_status;
            replaced_next = cmd.finish_replace;
            idx_next      = '0;
            len_next      = cmd.finish_replace ? newlen_w[TCW-1:0] : text_count_reg;
        end

        if (cmd.emit_rd)
        begin
            sel_repl_next = emit_in_repl;
        end

        if (cmd.emit_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_last_next   = st.emit_last;
            idx_next        = idx_reg + 1'b1;
            if (len_reg == '0)
            begin
                out_byte_next = '0;
            end
            else
            begin
                out_byte_next = sel_repl_reg ? rep_rdata : txt_rdata;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_count_reg    <= '0;
            pattern_count_reg <= '0;
            repl_count_reg    <= '0;
            overflow_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            text_count_reg    <= text_count_next;
            pattern_count_reg <= pattern_count_next;
            repl_count_reg    <= repl_count_next;
            overflow_reg      <= overflow_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        len_reg        <= len_next;
        status_reg     <= status_next;
        replaced_reg   <= replaced_next;
        sel_repl_reg   <= sel_repl_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = out_status_reg;
    assign last_out  = out_last_reg;

endmodule

[design/sfr_ctrl.sv]
module sfr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfr_pkg::sfr_stat_t st,
    output sfr_pkg::sfr_cmd_t  cmd
);
    import sfr_pkg::*;

    sfr_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (st.start_item)
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_DECIDE;
                    end
                end
            end
            // Checks the position and ends the job or issues its first compare.
            ST_DECIDE:
            begin
                priority if (st.overflow)
                begin
                    cmd.finish        = 1'b1;
                    cmd.finish_status = STATUS_OVERFLOW;
                    state_next        = ST_EMIT_RD;
                end
                else if (!st.pat_fits)
                begin
                    cmd.finish        = 1'b1;
                    cmd.finish_status = STATUS_NOT_FOUND;
                    state_next        = ST_EMIT_RD;
                end
                else if (st.pat_empty)
                begin
                    cmd.finish         = 1'b1;
                    cmd.finish_status  = st.too_long ? STATUS_TOO_LONG : STATUS_REPLACED;
                    cmd.finish_replace = !st.too_long;
                    state_next         = ST_EMIT_RD;
                end
                else
                begin
                    cmd.search_rd = 1'b1;
                    state_next    = ST_SEARCH_CMP;
                end
            end
            ST_SEARCH_RD:
            begin
                cmd.search_rd = 1'b1;
                state_next    = ST_SEARCH_CMP;
            end
            ST_SEARCH_CMP:
            begin
                if (st.byte_eq)
                begin
                    if (st.k_last)
                    begin
                        cmd.finish         = 1'b1;
                        cmd.finish_status  = st.too_long ? STATUS_TOO_LONG : STATUS_REPLACED;
                        cmd.finish_replace = !st.too_long;
                        state_next         = ST_EMIT_RD;
                    end
                    else
                    begin
                        cmd.next_k = 1'b1;
                        state_next = ST_SEARCH_RD;
                    end
                end
                else
                begin
                    cmd.next_pos = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (st.emit_last)
                    begin
                        cmd.clear_job = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/substring_find_replace_first.sv]
// Find and replace the first occurrence of a pattern in a text.
// The load channel takes one byte per transfer: command selects the pattern,
// replacement or text store. The text byte marked end_of_text starts the job,
// and the load channel stays not ready until the job's last result byte has
// been placed in the output register.
// The search walks candidate positions in order: each compare reads in DECIDE
// (first byte of a position) or SEARCH_RD (every further matching byte) and
// compares in SEARCH_CMP, one text and one pattern memory read per compare.
// With no search needed (overflow, empty pattern, pattern longer than text)
// DECIDE ends the job and the first result comes via EMIT_RD and EMIT_OUT.
// The result channel then gives one byte per EMIT_RD, EMIT_OUT pass, each
// with the job status, last_out on the final byte; an empty result gives a
// single zero byte with last_out set. A stall on the result channel holds
// the output register and the job in place; nothing is lost.
// Reset empties all stores and clears overflow and out_valid; contents stay.
module substring_find_replace_first #(
    parameter int BUFFER_BYTES  = sfr_pkg::BUFFER_BYTES_DEF,
    parameter int PATTERN_BYTES = sfr_pkg::PATTERN_BYTES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    sfr_load_if.sink     load,
    sfr_result_if.source result
);
    import sfr_pkg::*;

    sfr_cmd_t  cmd;
    sfr_stat_t st;

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (load.valid),
        .in_ready (load.ready),
        .st       (st),
        .cmd      (cmd)
    );

    sfr_datapath #(
        .BUFFER_BYTES  (BUFFER_BYTES),
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (load.command),
        .data_byte   (load.data_byte),
        .end_of_text (load.end_of_text),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_byte    (result.out_byte),
        .status      (result.status),
        .last_out    (result.last_out)
    );

endmodule

[design/sfr_checker.sv]
module sfr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               load_valid,
    input logic               load_ready,
    input sfr_pkg::cmd_code_t load_command,
    input logic               load_end_of_text,
    input logic               result_valid,
    input logic               result_ready,
    input sfr_pkg::byte_t     result_out_byte,
    input sfr_pkg::status_t   result_status,
    input logic               result_last_out
);
    import sfr_pkg::*;

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_out_byte)
            && $stable(result_status) && $stable(result_last_out))
    else $error("stalled result changed");

    // The end-of-text transfer starts a job, which blocks further loads.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && load_ready && load_command == CMD_TEXT && load_end_of_text
            |=> !load_ready)
    else $error("load accepted right after end of text");

    // While a job still has bytes to give, no load is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last_out |-> !load_ready)
    else $error("load ready in the middle of a job");

    // A valid result carries a fully known payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown({result_out_byte, result_status, result_last_out}))
    else $error("result payload unknown");

endmodule

bind substring_find_replace_first sfr_checker u_sfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .load_valid       (load.valid),
    .load_ready       (load.ready),
    .load_command     (load.command),
    .load_end_of_text (load.end_of_text),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_out_byte  (result.out_byte),
    .result_status    (result.status),
    .result_last_out  (result.last_out)
);
